/* src/rre_pkg.sv */
// Shared types and constants for the RV32I R-type execute block.
// Used by rre_front, rre_queue, rre_back and rv32i_rtype_execute_top.
package rre_pkg;

	localparam int XLEN      = 32;
	localparam int REG_AW    = 5;
	localparam int REG_DEPTH = 1 << REG_AW;
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_AW    = 1;

	localparam logic [1:0] CMD_EXEC  = 2'd0;
	localparam logic [1:0] CMD_WRITE = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;

	localparam logic [6:0] FUNCT7_BASE = 7'h00;
	localparam logic [6:0] FUNCT7_ALT  = 7'h20;

	localparam logic [2:0] F3_ADD  = 3'd0;
	localparam logic [2:0] F3_SLL  = 3'd1;
	localparam logic [2:0] F3_SLT  = 3'd2;
	localparam logic [2:0] F3_SLTU = 3'd3;
	localparam logic [2:0] F3_XOR  = 3'd4;
	localparam logic [2:0] F3_SR   = 3'd5;
	localparam logic [2:0] F3_OR   = 3'd6;
	localparam logic [2:0] F3_AND  = 3'd7;

	typedef enum logic [1:0] {
		KIND_ALU,
		KIND_WRITE,
		KIND_READ,
		KIND_NOP
	} kind_t;

	typedef enum logic [3:0] {
		OP_ADD,
		OP_SUB,
		OP_SLL,
		OP_SLT,
		OP_SLTU,
		OP_XOR,
		OP_SRL,
		OP_SRA,
		OP_OR,
		OP_AND
	} alu_op_t;

	typedef struct packed {
		logic [1:0]        cmd;
		logic [XLEN-1:0]   instr;
		logic [REG_AW-1:0] reg_index;
		logic [XLEN-1:0]   reg_value;
	} in_t;

	typedef struct packed {
		logic [XLEN-1:0]   value;
		logic [REG_AW-1:0] dest_index;
		logic              wrote;
		logic              illegal;
	} out_t;

	// Decoded word as it travels from the front end to the back end.
	typedef struct packed {
		kind_t             kind;
		alu_op_t           op;
		logic              illegal;
		logic [REG_AW-1:0] rs1;
		logic [REG_AW-1:0] rs2;
		logic [REG_AW-1:0] dest;
		logic [XLEN-1:0]   wdata;
	} uop_t;

endpackage

/* src/rre_front.sv */
// Front end: classifies an incoming word and decodes the R-type fields.
// Depends on rre_pkg.
module rre_front (
	input  rre_pkg::in_t  in_data,
	output rre_pkg::uop_t uop
);

	logic [2:0] f3;
	logic [6:0] f7;
	logic       base;
	logic       alt;

	assign f3   = in_data.instr[14:12];
	assign f7   = in_data.instr[31:25];
	assign base = (f7 == rre_pkg::FUNCT7_BASE);
	assign alt  = (f7 == rre_pkg::FUNCT7_ALT);

	always_comb begin
		uop.kind    = rre_pkg::KIND_NOP;
		uop.op      = rre_pkg::OP_ADD;
		uop.illegal = 1'b0;
		uop.rs1     = '0;
		uop.rs2     = '0;
		uop.dest    = '0;
		uop.wdata   = in_data.reg_value;
		case (in_data.cmd)
			rre_pkg::CMD_EXEC: begin
				uop.kind = rre_pkg::KIND_ALU;
				uop.rs1  = in_data.instr[19:15];
				uop.rs2  = in_data.instr[24:20];
				uop.dest = in_data.instr[11:7];
				case (f3)
					rre_pkg::F3_ADD: begin
						uop.op      = alt ? rre_pkg::OP_SUB : rre_pkg::OP_ADD;
						uop.illegal = !(base || alt);
					end
					rre_pkg::F3_SLL: begin
						uop.op      = rre_pkg::OP_SLL;
						uop.illegal = !base;
					end
					rre_pkg::F3_SLT: begin
						uop.op      = rre_pkg::OP_SLT;
						uop.illegal = !base;
					end
					rre_pkg::F3_SLTU: begin
						uop.op      = rre_pkg::OP_SLTU;
						uop.illegal = !base;
					end
					rre_pkg::F3_XOR: begin
						uop.op      = rre_pkg::OP_XOR;
						uop.illegal = !base;
					end
					rre_pkg::F3_SR: begin
						uop.op      = alt ? rre_pkg::OP_SRA : rre_pkg::OP_SRL;
						uop.illegal = !(base || alt);
					end
					rre_pkg::F3_OR: begin
						uop.op      = rre_pkg::OP_OR;
						uop.illegal = !base;
					end
					default: begin
						uop.op      = rre_pkg::OP_AND;
						uop.illegal = !base;
					end
				endcase
			end
			rre_pkg::CMD_WRITE: begin
				uop.kind = rre_pkg::KIND_WRITE;
				uop.dest = in_data.reg_index;
			end
			rre_pkg::CMD_READ: begin
				uop.kind = rre_pkg::KIND_READ;
				uop.rs1  = in_data.reg_index;
				uop.dest = in_data.reg_index;
			end
			default: begin
				uop.kind = rre_pkg::KIND_NOP;
			end
		endcase
	end

endmodule

/* src/rre_queue.sv */
// Two-entry queue of decoded words between the front and back ends.
// Depends on rre_pkg.
module rre_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  rre_pkg::uop_t push_data,
	output logic          pop_valid,
	input  logic          pop_ready,
	output rre_pkg::uop_t pop_data
);

	rre_pkg::uop_t                  mem_q [rre_pkg::QUEUE_DEPTH];
	logic [rre_pkg::QUEUE_AW-1:0]   wr_ptr_q;
	logic [rre_pkg::QUEUE_AW-1:0]   rd_ptr_q;
	logic [rre_pkg::QUEUE_AW:0]     count_q;
	logic                           push;
	logic                           pop;

	assign push_ready = (count_q != (rre_pkg::QUEUE_AW+1)'(rre_pkg::QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* src/rre_back.sv */
// Back end: register file read, ALU, write-back and output register.
// Depends on rre_pkg.
module rre_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          uop_valid,
	output logic          uop_ready,
	input  rre_pkg::uop_t uop,
	output logic          out_valid,
	input  logic          out_ready,
	output rre_pkg::out_t out_data
);

	localparam int XLEN   = rre_pkg::XLEN;
	localparam int REG_AW = rre_pkg::REG_AW;

	logic [XLEN-1:0]             rf_mem [rre_pkg::REG_DEPTH];
	logic [rre_pkg::REG_DEPTH-1:0] rf_vld_q;

	// Execute stage.
	logic                valid_s2;
	rre_pkg::uop_t       uop_s2;
	logic [XLEN-1:0]     rdata1_s2;
	logic [XLEN-1:0]     rdata2_s2;
	logic                rvld1_s2;
	logic                rvld2_s2;
	logic                fwd_en_s2;
	logic [REG_AW-1:0]   fwd_addr_s2;
	logic [XLEN-1:0]     fwd_data_s2;

	logic                out_valid_q;
	rre_pkg::out_t       out_q;

	logic                fire;
	logic                advance;
	logic                take;
	logic [XLEN-1:0]     a;
	logic [XLEN-1:0]     b;
	logic [4:0]          sh;
	logic [XLEN-1:0]     alu;
	rre_pkg::out_t       res;

	assign fire      = valid_s2 && (!out_valid_q || out_ready);
	assign advance   = !valid_s2 || fire;
	assign uop_ready = advance;
	assign take      = uop_valid && advance;

	// The write retiring in the same cycle as the read is not seen by the
	// memory read, so it is bypassed here.
	always_comb begin
		a = rvld1_s2 ? rdata1_s2 : '0;
		b = rvld2_s2 ? rdata2_s2 : '0;
		if (fwd_en_s2 && fwd_addr_s2 == uop_s2.rs1) begin
			a = fwd_data_s2;
		end
		if (fwd_en_s2 && fwd_addr_s2 == uop_s2.rs2) begin
			b = fwd_data_s2;
		end
	end

	assign sh = b[4:0];

	always_comb begin
		case (uop_s2.op)
			rre_pkg::OP_ADD:  alu = a + b;
			rre_pkg::OP_SUB:  alu = a - b;
			rre_pkg::OP_SLL:  alu = a << sh;
			rre_pkg::OP_SLT:  alu = XLEN'($signed(a) < $signed(b));
			rre_pkg::OP_SLTU: alu = XLEN'(a < b);
			rre_pkg::OP_XOR:  alu = a ^ b;
			rre_pkg::OP_SRL:  alu = a >> sh;
			rre_pkg::OP_SRA:  alu = XLEN'($signed(a) >>> sh);
			rre_pkg::OP_OR:   alu = a | b;
			rre_pkg::OP_AND:  alu = a & b;
			default:          alu = '0;
		endcase
	end

	always_comb begin
		res.value      = '0;
		res.dest_index = uop_s2.dest;
		res.wrote      = 1'b0;
		res.illegal    = 1'b0;
		case (uop_s2.kind)
			rre_pkg::KIND_ALU: begin
				if (uop_s2.illegal) begin
					res.illegal = 1'b1;
				end else begin
					res.value = alu;
					res.wrote = (uop_s2.dest != '0);
				end
			end
			rre_pkg::KIND_WRITE: begin
				res.wrote = (uop_s2.dest != '0);
				res.value = res.wrote ? uop_s2.wdata : '0;
			end
			rre_pkg::KIND_READ: begin
				res.value = a;
			end
			default: begin
				res.dest_index = '0;
			end
		endcase
	end

	// Register file: one write port, two registered read ports.
	always_ff @(posedge clk) begin
		if (fire && res.wrote) begin
			rf_mem[uop_s2.dest] <= res.value;
		end
		if (take) begin
			rdata1_s2 <= rf_mem[uop.rs1];
			rdata2_s2 <= rf_mem[uop.rs2];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rf_vld_q <= '0;
		end else if (fire && res.wrote) begin
			rf_vld_q[uop_s2.dest] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			uop_s2      <= uop;
			rvld1_s2    <= rf_vld_q[uop.rs1];
			rvld2_s2    <= rf_vld_q[uop.rs2];
			fwd_addr_s2 <= uop_s2.dest;
			fwd_data_s2 <= res.value;
		end
		if (fire) begin
			out_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2    <= 1'b0;
			fwd_en_s2   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				valid_s2 <= uop_valid;
			end
			if (take) begin
				fwd_en_s2 <= fire && res.wrote;
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

/* src/rv32i_rtype_execute_top.sv */
// Top level of the RV32I R-type execute block with its register file.
// Depends on rre_pkg, rre_front, rre_queue and rre_back.
//
// Usage:
//   Input channel (in_valid/in_ready/in_data) carries one command word:
//   execute an R-type instruction, write a register, or read a register.
//   Output channel (out_valid/out_ready/out_data) returns exactly one
//   result word per input word, in order.
//   A word accepted on the input passes through the queue, the execute
//   stage and the output register before its result shows on out_data.
//   Throughput: one word per cycle while out_ready stays high, including a
//   dependent instruction right after its producer; the retiring write is
//   bypassed into the next read. The execute stage and the 32-entry
//   register file with two read ports set that figure.
//   When the receiver stalls, the output register holds its word, the
//   execute stage fills, then the two-entry queue, and only then does
//   in_ready drop.
//   Reset clears all valid flags: every register reads as zero after reset
//   and x0 is never written.
module rv32i_rtype_execute_top (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  rre_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output rre_pkg::out_t out_data
);

	rre_pkg::uop_t dec_uop;
	rre_pkg::uop_t q_uop;
	logic          q_valid;
	logic          q_ready;

	rre_front u_front (
		.in_data (in_data),
		.uop     (dec_uop)
	);

	rre_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (in_valid),
		.push_ready (in_ready),
		.push_data  (dec_uop),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_data   (q_uop)
	);

	rre_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.uop_valid (q_valid),
		.uop_ready (q_ready),
		.uop       (q_uop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// An illegal instruction never updates the register file.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.illegal |-> !out_data.wrote && out_data.value == '0)
		else $error("illegal result reports a write or a value");

	// x0 is never reported as written.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.wrote |-> out_data.dest_index != '0)
		else $error("write reported to x0");

	// Input is never refused while the queue is empty.
	assert property (@(posedge clk) disable iff (!arst_n)
		!q_valid |-> in_ready)
		else $error("input stalled with an empty queue");

endmodule

/* sim/rv32i_rtype_execute_top_tb.sv */
// Self-checking testbench for rv32i_rtype_execute_top: a directed table, then random
// command words under varying sender idle and receiver stall, checked against a predictor.
// Depends on rre_pkg and the RTL under src.
`timescale 1ns / 100ps

module rv32i_rtype_execute_top_tb;
	import rre_pkg::*;

	localparam logic [1:0] CMD_NONE     = 2'd3;
	localparam logic [6:0] OPCODE_RTYPE = 7'h33;
	localparam int         CYCLE_LIMIT  = 200000;
	localparam int         PHASE_WORDS  = 450;
	localparam int         DRAIN_CYCLES = 8;

	typedef struct {
		in_t  word;
		logic typed;
		out_t result;
	} row_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_t  in_data;
	logic out_valid;
	logic out_ready;
	out_t out_data;

	// The typed expectation travels with the word and is taken at acceptance.
	logic in_typed;
	out_t in_typed_result;

	logic [XLEN-1:0] arch_regs [REG_DEPTH];
	out_t pending_results[$];
	out_t head_result;
	out_t fresh_result;
	row_t directed_rows[$];

	int mismatches;
	int words_in;
	int results_out;
	int illegal_seen;
	int writes_seen;
	int cycle_count;
	int sender_idle_pct;
	int ready_stall_pct;

	rv32i_rtype_execute_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [XLEN-1:0] rtype(input logic [6:0] f7, input logic [4:0] rs2,
			input logic [4:0] rs1, input logic [2:0] f3, input logic [4:0] rd);
		return {f7, rs2, rs1, f3, rd, OPCODE_RTYPE};
	endfunction

	function automatic in_t word(input logic [1:0] cmd, input logic [XLEN-1:0] instr,
			input logic [REG_AW-1:0] idx, input logic [XLEN-1:0] val);
		in_t w;
		w.cmd       = cmd;
		w.instr     = instr;
		w.reg_index = idx;
		w.reg_value = val;
		return w;
	endfunction

	function automatic out_t outcome(input logic [XLEN-1:0] v, input logic [REG_AW-1:0] d,
			input logic wr, input logic ill);
		out_t r;
		r.value      = v;
		r.dest_index = d;
		r.wrote      = wr;
		r.illegal    = ill;
		return r;
	endfunction

	function automatic logic [REG_AW-1:0] pick_reg();
		// Half the picks stay in the low registers so that results feed later words.
		if ($urandom_range(1))
			return REG_AW'($urandom_range(7));
		return REG_AW'($urandom_range(REG_DEPTH - 1));
	endfunction

	// Works out the result of one command word and updates the register copy.
	function automatic out_t execute_word(input in_t w);
		out_t            r;
		logic [XLEN-1:0] a;
		logic [XLEN-1:0] b;
		logic [XLEN-1:0] res;
		logic [4:0]      sh;
		logic [2:0]      f3;
		logic [6:0]      f7;
		logic            legal;
		r   = '0;
		res = '0;
		case (w.cmd)
			CMD_EXEC: begin
				f3    = w.instr[14:12];
				f7    = w.instr[31:25];
				a     = arch_regs[w.instr[19:15]];
				b     = arch_regs[w.instr[24:20]];
				sh    = b[4:0];
				legal = (f7 == FUNCT7_BASE);
				case (f3)
					F3_ADD: begin
						legal = legal || (f7 == FUNCT7_ALT);
						if (f7 == FUNCT7_ALT)
							res = a - b;
						else
							res = a + b;
					end
					F3_SLL:  res = a << sh;
					F3_SLT:  res = {31'b0, $signed(a) < $signed(b)};
					F3_SLTU: res = {31'b0, a < b};
					F3_XOR:  res = a ^ b;
					F3_SR: begin
						legal = legal || (f7 == FUNCT7_ALT);
						if (f7 == FUNCT7_ALT)
							res = $signed(a) >>> sh;
						else
							res = a >> sh;
					end
					F3_OR:   res = a | b;
					default: res = a & b;
				endcase
				r.dest_index = w.instr[11:7];
				if (legal) begin
					r.value = res;
					if (w.instr[11:7] != '0) begin
						arch_regs[w.instr[11:7]] = res;
						r.wrote = 1'b1;
					end
				end else begin
					r.illegal = 1'b1;
				end
			end
			CMD_WRITE: begin
				r.dest_index = w.reg_index;
				if (w.reg_index != '0) begin
					arch_regs[w.reg_index] = w.reg_value;
					r.wrote = 1'b1;
				end
				r.value = arch_regs[w.reg_index];
			end
			CMD_READ: begin
				r.dest_index = w.reg_index;
				r.value      = arch_regs[w.reg_index];
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [XLEN-1:0] got,
			input logic [XLEN-1:0] want);
		$display("ERROR at %0t: %s got 0x%08h, expected 0x%08h", $time, what, got, want);
		mismatches++;
	endtask

	// Called at a falling edge; returns at the falling edge after the word is taken.
	task automatic send_word(input in_t w, input logic typed, input out_t want);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid        <= 1'b1;
		in_data         <= w;
		in_typed        <= typed;
		in_typed_result <= want;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic add_row(input in_t w, input logic typed, input out_t want);
		row_t r;
		r.word   = w;
		r.typed  = typed;
		r.result = want;
		directed_rows.push_back(r);
	endtask

	task automatic run_phase(input int count, input int idle_pct, input int stall_pct);
		in_t             w;
		logic [2:0]      f3;
		logic [6:0]      f7;
		logic [XLEN-1:0] val;
		int              pick;
		sender_idle_pct = idle_pct;
		ready_stall_pct = stall_pct;
		for (int i = 0; i < count; i++) begin
			w    = word(CMD_EXEC, $urandom, REG_AW'($urandom), $urandom);
			pick = $urandom_range(99);
			if (pick < 15) begin
				case ($urandom_range(6))
					0: val = '0;
					1: val = '1;
					2: val = 32'h8000_0000;
					3: val = 32'h7FFF_FFFF;
					4: val = XLEN'($urandom_range(40));
					default: val = $urandom;
				endcase
				w.cmd       = CMD_WRITE;
				w.reg_index = pick_reg();
				w.reg_value = val;
			end else if (pick < 25) begin
				w.cmd       = CMD_READ;
				w.reg_index = pick_reg();
			end else if (pick < 29) begin
				w.cmd = CMD_NONE;
			end else if (pick < 34) begin
				// Raw word: any funct7, any opcode bits.
				w.cmd = CMD_EXEC;
			end else if (pick < 41) begin
				f3 = 3'($urandom_range(7));
				do f7 = 7'($urandom_range(127));
				while (f7 == FUNCT7_BASE ||
					((f3 == F3_ADD || f3 == F3_SR) && f7 == FUNCT7_ALT));
				w.instr = rtype(f7, pick_reg(), pick_reg(), f3, pick_reg());
			end else begin
				f3 = 3'($urandom_range(7));
				f7 = FUNCT7_BASE;
				if ((f3 == F3_ADD || f3 == F3_SR) && $urandom_range(1))
					f7 = FUNCT7_ALT;
				w.instr = rtype(f7, pick_reg(), pick_reg(), f3, pick_reg());
				if ($urandom_range(3) == 0)
					w.instr[6:0] = 7'($urandom);
			end
			send_word(w, 1'b0, '0);
		end
	endtask

	always @(negedge clk)
		out_ready <= ($urandom_range(99) >= ready_stall_pct);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d results pending",
				cycle_count, pending_results.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				results_out++;
				if (pending_results.size() == 0) begin
					report_mismatch("result with nothing pending, value", out_data.value, '0);
				end else begin
					head_result = pending_results.pop_front();
					if (out_data.value !== head_result.value)
						report_mismatch("value", out_data.value, head_result.value);
					if (out_data.dest_index !== head_result.dest_index)
						report_mismatch("dest_index", XLEN'(out_data.dest_index),
							XLEN'(head_result.dest_index));
					if (out_data.wrote !== head_result.wrote)
						report_mismatch("wrote", XLEN'(out_data.wrote), XLEN'(head_result.wrote));
					if (out_data.illegal !== head_result.illegal)
						report_mismatch("illegal", XLEN'(out_data.illegal),
							XLEN'(head_result.illegal));
					illegal_seen += head_result.illegal;
					writes_seen  += head_result.wrote;
				end
			end
			if (in_valid && in_ready) begin
				words_in++;
				// The predictor runs on every word so the register copy stays current.
				fresh_result = execute_word(in_data);
				if (in_typed)
					fresh_result = in_typed_result;
				pending_results.push_back(fresh_result);
			end
		end
	end

	initial begin
		arst_n          = 1'b0;
		in_valid        = 1'b0;
		in_data         = '0;
		in_typed        = 1'b0;
		in_typed_result = '0;
		out_ready       = 1'b0;
		mismatches      = 0;
		words_in        = 0;
		results_out     = 0;
		illegal_seen    = 0;
		writes_seen     = 0;
		cycle_count     = 0;
		sender_idle_pct = 0;
		ready_stall_pct = 0;
		foreach (arch_regs[i])
			arch_regs[i] = '0;

		add_row(word(CMD_READ, '0, 5'd5, '0), 1'b1, outcome('0, 5'd5, 1'b0, 1'b0));
		add_row(word(CMD_WRITE, '0, 5'd0, '1), 1'b1, outcome('0, 5'd0, 1'b0, 1'b0));
		add_row(word(CMD_WRITE, '0, 5'd1, '1), 1'b1, outcome('1, 5'd1, 1'b1, 1'b0));
		add_row(word(CMD_WRITE, '0, 5'd2, 32'h8000_0000), 1'b1,
			outcome(32'h8000_0000, 5'd2, 1'b1, 1'b0));
		add_row(word(CMD_WRITE, '0, 5'd3, 32'h7FFF_FFFF), 1'b1,
			outcome(32'h7FFF_FFFF, 5'd3, 1'b1, 1'b0));
		add_row(word(CMD_WRITE, '0, 5'd4, 32'h1), 1'b1, outcome(32'h1, 5'd4, 1'b1, 1'b0));
		add_row(word(CMD_WRITE, '0, 5'd31, 32'h1F), 1'b1, outcome(32'h1F, 5'd31, 1'b1, 1'b0));
		add_row(word(CMD_EXEC, rtype(FUNCT7_BASE, 5'd4, 5'd1, F3_ADD, 5'd5), '0, '0), 1'b0, '0);
		add_row(word(CMD_EXEC, rtype(FUNCT7_ALT, 5'd4, 5'd2, F3_ADD, 5'd6), '0, '0), 1'b0, '0);
		add_row(word(CMD_EXEC, rtype(FUNCT7_BASE, 5'd31, 5'd1, F3_SLL, 5'd7), '0, '0), 1'b0, '0);
		add_row(word(CMD_EXEC, rtype(FUNCT7_BASE, 5'd3, 5'd2, F3_SLT, 5'd8), '0, '0), 1'b0, '0);
		add_row(word(CMD_EXEC, rtype(FUNCT7_BASE, 5'd3, 5'd2, F3_SLTU, 5'd9), '0, '0), 1'b0, '0);
		add_row(word(CMD_EXEC, rtype(FUNCT7_BASE, 5'd3, 5'd1, F3_XOR, 5'd10), '0, '0), 1'b0, '0);
		add_row(word(CMD_EXEC, rtype(FUNCT7_BASE, 5'd31, 5'd2, F3_SR, 5'd11), '0, '0), 1'b0, '0);
		add_row(word(CMD_EXEC, rtype(FUNCT7_ALT, 5'd31, 5'd2, F3_SR, 5'd12), '0, '0), 1'b0, '0);
		add_row(word(CMD_EXEC, rtype(FUNCT7_BASE, 5'd3, 5'd2, F3_OR, 5'd13), '0, '0), 1'b0, '0);
		add_row(word(CMD_EXEC, rtype(FUNCT7_BASE, 5'd3, 5'd1, F3_AND, 5'd14), '0, '0), 1'b0, '0);
		// Destination x0 still reports the sum but must not write.
		add_row(word(CMD_EXEC, rtype(FUNCT7_BASE, 5'd1, 5'd1, F3_ADD, 5'd0), '0, '0), 1'b0, '0);
		add_row(word(CMD_EXEC, rtype(7'h7F, 5'd1, 5'd2, F3_ADD, 5'd15), '0, '0), 1'b1,
			outcome('0, 5'd15, 1'b0, 1'b1));
		add_row(word(CMD_EXEC, rtype(FUNCT7_ALT, 5'd1, 5'd2, F3_OR, 5'd31), '0, '0), 1'b1,
			outcome('0, 5'd31, 1'b0, 1'b1));
		// Opcode bits are ignored by the decoder.
		add_row(word(CMD_EXEC, rtype(FUNCT7_BASE, 5'd4, 5'd3, F3_ADD, 5'd16) | 32'h7F, '0, '0),
			1'b0, '0);
		add_row(word(CMD_NONE, '1, 5'd31, '1), 1'b1, outcome('0, 5'd0, 1'b0, 1'b0));
		// A producer followed at once by its consumer exercises the bypass.
		add_row(word(CMD_EXEC, rtype(FUNCT7_ALT, 5'd1, 5'd1, F3_ADD, 5'd1), '0, '0), 1'b0, '0);
		add_row(word(CMD_EXEC, rtype(FUNCT7_BASE, 5'd3, 5'd1, F3_ADD, 5'd17), '0, '0), 1'b0, '0);
		add_row(word(CMD_READ, '0, 5'd17, '0), 1'b0, '0);

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[i])
			send_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].result);

		run_phase(PHASE_WORDS, 0, 0);
		run_phase(PHASE_WORDS, 59, 0);
		// Let the pipeline empty completely before going on.
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		@(negedge clk);
		run_phase(PHASE_WORDS, 0, 59);
		run_phase(PHASE_WORDS, 28, 28);

		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run covered %0d command words and %0d results in %0d cycles,", words_in,
			results_out, cycle_count);
		$display("including %0d register updates and %0d illegal encodings.", writes_seen,
			illegal_seen);
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
